### rtl/ldl_pkg.sv
// Shared types and constants for the list duplicate limiter.
// Used by ldl_cell and list_duplicate_limiter_core; depends on nothing.

package ldl_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 256;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned ALLOW_W        = 9;
  localparam logic [ALLOW_W-1:0] ALLOW_RESET = 9'd1;

  // One list element as stored and compared: kind and raw word.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
  } ldl_elem_t;

  typedef enum logic [1:0] {
    LDL_IDLE,
    LDL_SWEEP,
    LDL_DONE
  } ldl_state_e;

endpackage

### rtl/list_duplicate_limiter_core.sv
// Top level of the list duplicate limiter: stream ports, control sequencer
// and the chain of ldl_cell compare cells. Depends on ldl_pkg and ldl_cell.

// The block takes a list one element per input beat (kind in tuser, word in
// tdata, tlast closing the list) and returns one beat per element, echoing
// it with a kept flag. An element is kept when fewer than allow_count earlier
// elements of the same list carry the same kind and word; allow_count = 0
// drops everything, and anything from LIST_DEPTH upwards keeps every element
// that fits. Elements beyond LIST_DEPTH in one list are not stored and come
// back with kept = 0. The list store is a row of LIST_DEPTH cells; on each
// accepted beat the element is written into the next free cell and a count
// token is launched down the row, one cell per clock, each cell adding its
// match. The sweep lasts until the token has walked the whole cell row; its
// final count is registered, the verdict is formed from it and loaded into
// the output register once that is free, and no new beat is taken before
// that load. The result then waits there, so the next element is accepted
// while the previous result still waits for m_axis_tready. The cells need no
// clearing after reset: only cells written in the current list are counted.
// allow_count is written through the cfg channel, always ready, and must
// only change while the block is idle.

module list_duplicate_limiter_core #(
  parameter int unsigned LIST_DEPTH = ldl_pkg::LIST_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input beats
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ldl_pkg::WORD_W-1:0]   s_axis_tdata,  // [31:0] elem_word
  input  logic [ldl_pkg::KIND_W-1:0]   s_axis_tuser,  // [1:0] elem_kind
  input  logic                         s_axis_tlast,  // last_elem
  // result beats
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ldl_pkg::WORD_W-1:0]   m_axis_tdata,  // [31:0] out_word
  output logic [ldl_pkg::KIND_W:0]     m_axis_tuser,  // [0] kept, [2:1] out_kind
  output logic                         m_axis_tlast,  // out_last
  // allow_count register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ldl_pkg::ALLOW_W-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = $clog2(LIST_DEPTH);
  localparam int unsigned PosW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CntW = IdxW;
  localparam int unsigned CmpW = (CntW > ldl_pkg::ALLOW_W) ? CntW : ldl_pkg::ALLOW_W;

  ldl_pkg::ldl_state_e state_q, state_d;

  logic [ldl_pkg::ALLOW_W-1:0] allow_q;
  logic [PosW-1:0]             pos_q, pos_d;
  logic                        in_acc, in_range;
  logic                        start_q;

  // Element under test, held for the whole sweep.
  ldl_pkg::ldl_elem_t probe_q;
  logic               probe_last_q;
  logic               probe_range_q;
  logic [PosW-1:0]    limit_q;

  logic [CntW-1:0]    fin_cnt_q;
  logic               out_free, load_out;

  logic               out_vld_q;
  logic               out_kept_q;
  ldl_pkg::ldl_elem_t out_elem_q;
  logic               out_last_q;
  logic               kept_d;

  ldl_pkg::ldl_elem_t in_elem;

  logic                tok_vld [0:LIST_DEPTH];
  logic [CntW-1:0]     tok_cnt [0:LIST_DEPTH];

  assign in_elem  = '{kind: s_axis_tuser, word: s_axis_tdata};
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = (pos_q < PosW'(LIST_DEPTH));
  assign out_free = !out_vld_q || m_axis_tready;

  assign cfg_ready_o = 1'b1;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldl_pkg::LDL_IDLE:  if (in_acc) state_d = ldl_pkg::LDL_SWEEP;
      ldl_pkg::LDL_SWEEP: if (tok_vld[LIST_DEPTH]) state_d = ldl_pkg::LDL_DONE;
      ldl_pkg::LDL_DONE:  if (out_free) state_d = ldl_pkg::LDL_IDLE;
      default:            state_d = ldl_pkg::LDL_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ldl_pkg::LDL_IDLE:  s_axis_tready = 1'b1;
      ldl_pkg::LDL_SWEEP: s_axis_tready = 1'b0;
      ldl_pkg::LDL_DONE:  load_out      = out_free;
      default:            s_axis_tready = 1'b0;
    endcase
  end

  // Advance the list position; return to zero after the last element.
  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        pos_d = '0;
      end else if (in_range) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Keep only stored elements whose match count stays below the allowance.
  assign kept_d = probe_range_q && (CmpW'(fin_cnt_q) < CmpW'(allow_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ldl_pkg::LDL_IDLE;
      allow_q   <= ldl_pkg::ALLOW_RESET;
      pos_q     <= '0;
      start_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      start_q <= in_acc;
      if (cfg_valid_i && cfg_ready_o) begin
        allow_q <= cfg_data_i;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      probe_q       <= in_elem;
      probe_last_q  <= s_axis_tlast;
      probe_range_q <= in_range;
      limit_q       <= pos_q;
    end
    if (tok_vld[LIST_DEPTH]) begin
      fin_cnt_q <= tok_cnt[LIST_DEPTH];
    end
    if (load_out) begin
      out_kept_q <= kept_d;
      out_elem_q <= probe_q;
      out_last_q <= probe_last_q;
    end
  end

  // Launch the count token into the first cell.
  assign tok_vld[0] = start_q;
  assign tok_cnt[0] = '0;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic wr_en;
    assign wr_en = in_acc && in_range && (pos_q[IdxW-1:0] == IdxW'(g));

    ldl_cell #(
      .CntW    (CntW),
      .PosW    (PosW),
      .CellIdx (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_en_i      (wr_en),
      .wr_elem_i    (in_elem),
      .probe_elem_i (probe_q),
      .limit_i      (limit_q),
      .tok_vld_i    (tok_vld[g]),
      .tok_cnt_i    (tok_cnt[g]),
      .tok_vld_o    (tok_vld[g+1]),
      .tok_cnt_o    (tok_cnt[g+1])
    );
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_elem_q.word;
  assign m_axis_tuser  = {out_elem_q.kind, out_kept_q};
  assign m_axis_tlast  = out_last_q;

  // The token only leaves the row while a sweep is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_vld[LIST_DEPTH] |-> state_q == ldl_pkg::LDL_SWEEP)
    else $error("count token left the cell row outside a sweep");

  // An accepted beat launches exactly one token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> start_q && state_q == ldl_pkg::LDL_SWEEP)
    else $error("accepted beat did not start a sweep");

  // The list position never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(LIST_DEPTH))
    else $error("list position beyond depth");

  // A zero allowance never keeps anything.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && allow_q == '0 |=> !out_kept_q)
    else $error("element kept with zero allowance");

endmodule

### rtl/ldl_cell.sv
// One cell of the compare chain: holds one stored element of the list and
// adds its match to the count token passing through. Depends on ldl_pkg.

module ldl_cell #(
  parameter int unsigned CntW    = 8,
  parameter int unsigned PosW    = 9,
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  ldl_pkg::ldl_elem_t  wr_elem_i,
  input  ldl_pkg::ldl_elem_t  probe_elem_i,
  input  logic [PosW-1:0]     limit_i,
  input  logic                tok_vld_i,
  input  logic [CntW-1:0]     tok_cnt_i,
  output logic                tok_vld_o,
  output logic [CntW-1:0]     tok_cnt_o
);

  ldl_pkg::ldl_elem_t entry_q;
  logic               tok_vld_q;
  logic [CntW-1:0]    tok_cnt_q, tok_cnt_d;
  logic               hit;

  // Count only entries written earlier in the current list.
  assign hit       = (entry_q == probe_elem_i) && (PosW'(CellIdx) < limit_i);
  assign tok_cnt_d = tok_cnt_i + CntW'(hit);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_elem_i;
    end
    tok_cnt_q <= tok_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_cnt_o = tok_cnt_q;

endmodule

### tb/tb_top.sv
// Self-checking bench for list_duplicate_limiter_core: element stream in, one
// verdict beat out per element, checked against an in-bench duplicate counter.
// Depends on ldl_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH      = ldl_pkg::LIST_DEPTH_DEF;
  localparam int unsigned KIND_W     = ldl_pkg::KIND_W;
  localparam int unsigned WORD_W     = ldl_pkg::WORD_W;
  localparam int unsigned ALLOW_W    = ldl_pkg::ALLOW_W;
  // Acceptance-to-result allowance for the final wait, as the count token
  // walks every cell of the row.
  localparam int unsigned LATENCY    = DEPTH + 2;
  localparam int          NUM_PHASES = 7;
  localparam int          PHASE_LEN  = 130;
  localparam int          NUM_ROWS   = 14;

  // Verdict beat as the core should return it.
  typedef struct packed {
    logic              kept;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    logic              last;
  } verdict_t;

  // One directed element; verdict typed in only where has_kept is set.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              has_kept;
    logic              kept;
  } elem_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [WORD_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]  s_axis_tuser;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [WORD_W-1:0]  m_axis_tdata;
  logic [KIND_W:0]    m_axis_tuser;
  logic               m_axis_tlast;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ALLOW_W-1:0] cfg_data_i;

  // Shadow of the core: elements of the current list, fill level, allowance.
  ldl_pkg::ldl_elem_t list_store [DEPTH];
  int unsigned        list_fill;
  logic [ALLOW_W-1:0] allow_limit;

  verdict_t           pending_verdicts [$];
  int unsigned        fail_count;
  idle_mode_e         idle_mode;
  elem_row_t          elem_rows [NUM_ROWS];
  logic [ALLOW_W-1:0] phase_allow [NUM_PHASES];

  list_duplicate_limiter_core #(
    .LIST_DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Idle odds for each side under the current mode.
  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      IDLE_SENDER: return 66;
      IDLE_BOTH:   return 31;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 66;
      IDLE_BOTH:     return 31;
      default:       return 0;
    endcase
  endfunction

  // Count earlier equal elements of the list, decide the verdict, then store
  // the element while there is room. The last flag rewinds the list, even for
  // an element that fell past the depth.
  function automatic verdict_t predict_verdict(logic [KIND_W-1:0] kind,
                                               logic [WORD_W-1:0] word,
                                               logic last);
    verdict_t           res;
    ldl_pkg::ldl_elem_t elem;
    int unsigned        hits;
    int unsigned        idx;
    elem.kind = kind;
    elem.word = word;
    res.kept  = 1'b0;
    res.kind  = kind;
    res.word  = word;
    res.last  = last;
    if (list_fill < DEPTH) begin
      hits = 0;
      for (idx = 0; idx < list_fill; idx++) begin
        if (list_store[idx] == elem) hits++;
      end
      res.kept = (hits < 32'(allow_limit));
      list_store[list_fill] = elem;
      list_fill++;
    end
    if (last) list_fill = 0;
    return res;
  endfunction

  // Receiver: drop tready at random under the stall odds of the mode.
  always @(posedge clk_i) begin
    m_axis_tready <= !roll(receiver_stall_pct());
  end

  task automatic report_mismatch(string field, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
  endtask

  // Check each result beat at the falling edge before the rising edge that
  // takes it; inputs and outputs are settled by then.
  always @(negedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected beat", '0, m_axis_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tuser[0] !== want.kept)
          report_mismatch("kept", WORD_W'(want.kept), WORD_W'(m_axis_tuser[0]));
        if (m_axis_tuser[KIND_W:1] !== want.kind)
          report_mismatch("kind", WORD_W'(want.kind), WORD_W'(m_axis_tuser[KIND_W:1]));
        if (m_axis_tdata !== want.word)
          report_mismatch("word", want.word, m_axis_tdata);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", WORD_W'(want.last), WORD_W'(m_axis_tlast));
      end
    end
  end

  // Offer one element, wait for the core to take it, and queue its verdict.
  // Entered and left just after a rising edge.
  task automatic send_elem(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word,
                           logic last, logic has_kept, logic kept);
    verdict_t res;
    while (roll(sender_idle_pct())) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    s_axis_tlast  <= last;
    @(negedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    res = predict_verdict(kind, word, last);
    if (has_kept) res.kept = kept;
    pending_verdicts.push_back(res);
  endtask

  // Close the stream for a while: lower tvalid, then wait out every verdict.
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write allow_count; only called with the core drained.
  task automatic write_allow(logic [ALLOW_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    allow_limit = value;
  endtask

  // Short list drawn mostly from a small pool so duplicates are common; mix in
  // near misses (one word bit flipped, or kind changed) and fresh values.
  task automatic send_random_list(int unsigned len);
    ldl_pkg::ldl_elem_t pool [4];
    ldl_pkg::ldl_elem_t elem;
    int unsigned        pool_n;
    int unsigned        idx;
    int unsigned        pick;
    pool_n = $urandom_range(4, 1);
    for (idx = 0; idx < 4; idx++) begin
      pool[idx].kind = KIND_W'($urandom_range(3, 0));
      case ($urandom_range(3, 0))
        0:       pool[idx].word = '0;
        1:       pool[idx].word = '1;
        default: pool[idx].word = $urandom();
      endcase
    end
    for (idx = 0; idx < len; idx++) begin
      pick = $urandom_range(99, 0);
      elem = pool[$urandom_range(pool_n - 1, 0)];
      if (pick >= 90) begin
        elem.kind = KIND_W'($urandom_range(3, 0));
        elem.word = $urandom();
      end else if (pick >= 82) begin
        elem.word[$urandom_range(WORD_W - 1, 0)] ^= 1'b1;
      end else if (pick >= 76) begin
        elem.kind = KIND_W'($urandom_range(3, 0));
      end
      send_elem(elem.kind, elem.word, idx == len - 1, 1'b0, 1'b0);
    end
  endtask

  // Long list: one value repeated for head_len beats, then random values up
  // to len; drives the match count to its ceiling and the list past depth.
  task automatic send_long_list(int unsigned len, int unsigned head_len);
    ldl_pkg::ldl_elem_t rep;
    int unsigned        idx;
    rep.kind = KIND_W'($urandom_range(3, 0));
    rep.word = $urandom();
    for (idx = 0; idx < len; idx++) begin
      if (idx < head_len)
        send_elem(rep.kind, rep.word, idx == len - 1, 1'b0, 1'b0);
      else
        send_elem(KIND_W'($urandom_range(3, 0)), $urandom(), idx == len - 1,
                  1'b0, 1'b0);
    end
  endtask

  initial begin : stimulus
    int          ph;
    int unsigned sent;
    int unsigned len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    fail_count    = 0;
    idle_mode     = IDLE_NONE;
    list_fill     = 0;
    allow_limit   = ldl_pkg::ALLOW_RESET;

    // Directed list under the reset allowance of one: the first copy of a
    // value is kept, any repeat dropped. Kind tag 3 is an ordinary tag;
    // kind alone or one word bit is enough to differ; the last flag
    // restarts the count.
    //               kind  word           last has  kept
    elem_rows[0]  = '{2'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1};
    elem_rows[1]  = '{2'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b0};
    elem_rows[2]  = '{2'd1, 32'h0000_0000, 1'b0, 1'b1, 1'b1};
    elem_rows[3]  = '{2'd3, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1};
    elem_rows[4]  = '{2'd3, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0};
    elem_rows[5]  = '{2'd2, 32'hFFFF_FFFE, 1'b0, 1'b1, 1'b1};
    elem_rows[6]  = '{2'd2, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1};
    elem_rows[7]  = '{2'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0};
    elem_rows[8]  = '{2'd0, 32'h0000_0001, 1'b1, 1'b1, 1'b1};
    elem_rows[9]  = '{2'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1};
    elem_rows[10] = '{2'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b0};
    elem_rows[11] = '{2'd2, 32'hA5A5_A5A5, 1'b1, 1'b1, 1'b1};
    elem_rows[12] = '{2'd1, 32'h5A5A_5A5A, 1'b0, 1'b0, 1'b0};
    elem_rows[13] = '{2'd1, 32'h5A5A_5A5A, 1'b1, 1'b0, 1'b0};

    // Allowance per random phase: zero, the list depth and the value below it,
    // and values around the reset one.
    phase_allow = '{9'd0, 9'd2, 9'd256, 9'd255, 9'd3, 9'd1, 9'd5};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (elem_rows[r])
      send_elem(elem_rows[r].kind, elem_rows[r].word, elem_rows[r].last,
                elem_rows[r].has_kept, elem_rows[r].kept);
    drain_verdicts();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      write_allow(phase_allow[ph]);
      // Allowance 256: every stored element kept, the rest dropped past
      // depth, with the last flag landing beyond it.
      if (phase_allow[ph] == 9'd256) send_long_list(DEPTH + 1, DEPTH + 1);
      // Allowance 255: the final stored copy sees 255 matches and is the
      // first to be dropped.
      if (phase_allow[ph] == 9'd255) send_long_list(DEPTH + 44, DEPTH);
      sent = 0;
      while (sent < PHASE_LEN) begin
        len = roll(15) ? 1 : $urandom_range(24, 2);
        send_random_list(len);
        sent += len;
      end
      drain_verdicts();
    end

    // Allow for stray beats after the last expected one.
    repeat (LATENCY + 8) @(posedge clk_i);
    fail_count += pending_verdicts.size();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
